@@ design/prpc_pkg.sv @@
// Package for the RAM probe pattern checker: operation codes, LFSR constants,
// the eight-step LFSR function and the result word layout. No dependencies.
package prpc_pkg;

	typedef enum logic [1:0] {
		OP_RESTART  = 2'd0,
		OP_GENERATE = 2'd1,
		OP_CHECK    = 2'd2
	} op_t;

	localparam logic [15:0] LFSR_SEED     = 16'hACE1;
	localparam logic [15:0] LFSR_MASK     = 16'hB400;
	localparam logic [14:0] NO_INDEX      = 15'h7FFF;
	localparam logic [7:0]  ALL_ONES_BYTE = 8'hFF;

	typedef struct packed {
		logic [15:0] state;
		logic [7:0]  pattern;
	} lfsr_step_t;

	// Packed with pattern_byte in the lowest bits, done_res on top.
	typedef struct packed {
		logic        done_res;
		logic        all_bytes_ff;
		logic [14:0] first_mismatch_index;
		logic [13:0] match_count;
		logic [7:0]  pattern_byte;
	} result_t;

	// Step the Galois LFSR eight times; shifted-out bits form the byte, MSB first.
	function automatic lfsr_step_t lfsr_next8(input logic [15:0] seed);
		lfsr_step_t r;
		logic [15:0] s;
		logic [7:0]  acc;
		logic        b;
		s   = seed;
		acc = '0;
		for (int k = 0; k < 8; k++) begin
			b   = s[0];
			s   = {1'b0, s[15:1]} ^ (b ? LFSR_MASK : 16'h0000);
			acc = {acc[6:0], b};
		end
		r.state   = s;
		r.pattern = acc;
		return r;
	endfunction

endpackage

@@ design/prpc_engine.sv @@
// Pattern and statistics engine of the RAM probe pattern checker: LFSR state,
// match counter, first-mismatch latch, all-0xFF flag, byte index, row register.
// Depends on prpc_pkg.
module prpc_engine #(
	parameter int ROW_BYTES = 50,
	parameter int MAX_ROWS  = 300
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [8:0]         cfg_wdata,
	input  logic               step,
	input  prpc_pkg::op_t      op,
	input  logic [7:0]         read_byte,
	output prpc_pkg::result_t  res
);

	localparam int ROWS_W  = $clog2(MAX_ROWS + 1);
	localparam int RANGE_W = $clog2(MAX_ROWS * ROW_BYTES + 1);

	logic [ROWS_W-1:0]  rows_q;
	logic [RANGE_W-1:0] range_bytes;

	logic [15:0]        lfsr_q, lfsr_d;
	logic [13:0]        match_q, match_d;
	logic [14:0]        bad_idx_q, bad_idx_d;
	logic               bad_valid_q, bad_valid_d;
	logic               all_ff_q, all_ff_d;
	logic [RANGE_W-1:0] idx_q, idx_d;
	logic [7:0]         pattern;
	logic               in_range;
	prpc_pkg::lfsr_step_t nxt;

	// Clamp the row count to 1..MAX_ROWS on write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ROWS_W'(1);
		end else if (cfg_we) begin
			if (cfg_wdata == 9'd0) begin
				rows_q <= ROWS_W'(1);
			end else if (int'(cfg_wdata) > MAX_ROWS) begin
				rows_q <= ROWS_W'(MAX_ROWS);
			end else begin
				rows_q <= ROWS_W'(cfg_wdata);
			end
		end
	end

	assign range_bytes = RANGE_W'(int'(rows_q) * ROW_BYTES);
	assign in_range    = idx_q < range_bytes;
	assign nxt         = prpc_pkg::lfsr_next8(lfsr_q);

	always_comb begin
		lfsr_d      = lfsr_q;
		match_d     = match_q;
		bad_idx_d   = bad_idx_q;
		bad_valid_d = bad_valid_q;
		all_ff_d    = all_ff_q;
		idx_d       = idx_q;
		pattern     = 8'h00;
		unique case (op)
			prpc_pkg::OP_RESTART: begin
				lfsr_d      = prpc_pkg::LFSR_SEED;
				match_d     = '0;
				bad_idx_d   = '0;
				bad_valid_d = 1'b0;
				all_ff_d    = 1'b1;
				idx_d       = '0;
			end
			prpc_pkg::OP_GENERATE: begin
				lfsr_d  = nxt.state;
				pattern = nxt.pattern;
			end
			prpc_pkg::OP_CHECK: begin
				// drop checks past the tested range
				if (in_range) begin
					lfsr_d  = nxt.state;
					pattern = nxt.pattern;
					if (read_byte != prpc_pkg::ALL_ONES_BYTE) begin
						all_ff_d = 1'b0;
					end
					if (read_byte == nxt.pattern) begin
						match_d = match_q + 14'd1;
					end else if (!bad_valid_q) begin
						bad_valid_d = 1'b1;
						bad_idx_d   = 15'(idx_q);
					end
					idx_d = idx_q + RANGE_W'(1);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q      <= prpc_pkg::LFSR_SEED;
			match_q     <= '0;
			bad_idx_q   <= '0;
			bad_valid_q <= 1'b0;
			all_ff_q    <= 1'b1;
			idx_q       <= '0;
		end else if (step) begin
			lfsr_q      <= lfsr_d;
			match_q     <= match_d;
			bad_idx_q   <= bad_idx_d;
			bad_valid_q <= bad_valid_d;
			all_ff_q    <= all_ff_d;
			idx_q       <= idx_d;
		end
	end

	always_comb begin
		res.pattern_byte         = pattern;
		res.match_count          = match_d;
		res.first_mismatch_index = bad_valid_d ? bad_idx_d : prpc_pkg::NO_INDEX;
		res.all_bytes_ff         = all_ff_d;
		res.done_res             = idx_d >= range_bytes;
	end

endmodule

@@ design/ram_probe_pattern_checker_unit.sv @@
// Top level of the RAM probe pattern checker: input register, engine, result
// register. Depends on prpc_pkg and prpc_engine.
//
//  channel | direction | tdata                | tuser
//  s_      | in        | read_byte            | operation
//  m_      | out       | result word (40 bit) | -
//  cfg_    | in        | probe_rows, clamped  | -
//
// One word per cycle while m_tready stays high; m_tvalid follows the result register.
// The eight LFSR steps and the compare sit between the input and result registers.
// Reset loads the seed, clears the statistics and sets probe_rows to one.
// A stalled output holds its word; the input register keeps taking words while
// the result register drains in the same cycle.
module ram_probe_pattern_checker_unit #(
	parameter int ROW_BYTES = 50,
	parameter int MAX_ROWS  = 300
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [8:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] read_byte
	input  logic [1:0]  s_tuser,  // [1:0] operation
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] pattern_byte, [21:8] match_count, [36:22] first_mismatch_index,
	// [37] all_bytes_ff, [38] done_res, [39] zero
	output logic [39:0] m_tdata
);

	logic              valid_s1;
	prpc_pkg::op_t     op_s1;
	logic [7:0]        byte_s1;
	logic              advance;
	prpc_pkg::result_t res;
	prpc_pkg::result_t res_q;
	logic              out_valid_q;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= prpc_pkg::op_t'(s_tuser);
			byte_s1 <= s_tdata;
		end
	end

	prpc_engine #(
		.ROW_BYTES(ROW_BYTES),
		.MAX_ROWS (MAX_ROWS)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.step     (advance),
		.op       (op_s1),
		.read_byte(byte_s1),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, res_q};

endmodule

@@ design/prpc_checker.sv @@
// Port-level checks for the RAM probe pattern checker, bound to the top level.
// Depends on ram_probe_pattern_checker_unit port names only.
module prpc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);

	logic        seen_q;
	logic [13:0] match_q;
	logic [14:0] bad_q;
	logic        out_acc;

	assign out_acc = m_tvalid && m_tready;

	// hold the last delivered statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= 1'b0;
			match_q <= '0;
			bad_q   <= 15'h7FFF;
		end else if (out_acc) begin
			seen_q  <= 1'b1;
			match_q <= m_tdata[21:8];
			bad_q   <= m_tdata[36:22];
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	a_match_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && seen_q |-> m_tdata[21:8] == match_q ||
			m_tdata[21:8] == match_q + 14'd1 || m_tdata[21:8] == 14'd0)
		else $error("match count jumped");

	a_first_bad: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && seen_q |-> m_tdata[36:22] == bad_q || bad_q == 15'h7FFF ||
			m_tdata[36:22] == 15'h7FFF)
		else $error("first mismatch index moved after latching");

endmodule

bind ram_probe_pattern_checker_unit prpc_checker u_prpc_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

@@ bench/ram_probe_pattern_checker_unit_tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for ram_probe_pattern_checker_unit: directed cases, then write/read
// passes with injected faults, predicted word by word. Depends on prpc_pkg and the RTL.
module ram_probe_pattern_checker_unit_tb;

	localparam int ROW_BYTES   = 50;
	localparam int MAX_ROWS    = 300;
	localparam int QUIET_LIMIT = 1000;
	localparam int SHOWN_ERRS  = 10;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [8:0]  cfg_wdata = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = '0;  // [7:0] read_byte
	logic [1:0]  s_tuser   = '0;  // [1:0] operation
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	// [7:0] pattern_byte, [21:8] match_count, [36:22] first_mismatch_index,
	// [37] all_bytes_ff, [38] done_res, [39] zero
	logic [39:0] m_tdata;

	// predicted engine state
	logic [15:0] mdl_lfsr      = prpc_pkg::LFSR_SEED;
	logic [13:0] mdl_matches   = '0;
	logic [14:0] mdl_bad_index = '0;
	logic        mdl_bad_seen  = 1'b0;
	logic        mdl_all_ff    = 1'b1;
	int          mdl_checked   = 0;
	int          mdl_rows      = 1;

	prpc_pkg::result_t pending_status[$];
	int      words_sent  = 0;
	int      err_count   = 0;
	int      quiet_cycles = 0;
	int      stall_left  = 0;
	bit      gaps_on     = 1'b1;

	ram_probe_pattern_checker_unit #(
		.ROW_BYTES(ROW_BYTES),
		.MAX_ROWS (MAX_ROWS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// Eight Galois steps; bits shifted out build the byte, first bit ends up as MSB.
	function automatic logic [7:0] lfsr_byte(input logic [15:0] st_in, output logic [15:0] st_out);
		logic [15:0] st;
		logic [7:0]  acc;
		logic        out_bit;
		st  = st_in;
		acc = '0;
		for (int k = 0; k < 8; k++) begin
			out_bit = st[0];
			st      = st >> 1;
			if (out_bit)
				st = st ^ prpc_pkg::LFSR_MASK;
			acc = {acc[6:0], out_bit};
		end
		st_out = st;
		return acc;
	endfunction

	function automatic logic [7:0] peek_pattern();
		logic [15:0] scratch;
		return lfsr_byte(mdl_lfsr, scratch);
	endfunction

	function automatic bit in_range();
		return mdl_checked < mdl_rows * ROW_BYTES;
	endfunction

	function automatic void clear_model();
		mdl_lfsr      = prpc_pkg::LFSR_SEED;
		mdl_matches   = '0;
		mdl_bad_index = '0;
		mdl_bad_seen  = 1'b0;
		mdl_all_ff    = 1'b1;
		mdl_checked   = 0;
	endfunction

	function automatic prpc_pkg::result_t predict_status(input logic [1:0] op,
		input logic [7:0] rd);
		prpc_pkg::result_t r;
		logic [7:0]  want;
		r = '0;
		if (op == prpc_pkg::OP_RESTART) begin
			clear_model();
		end else if (op == prpc_pkg::OP_GENERATE) begin
			r.pattern_byte = lfsr_byte(mdl_lfsr, mdl_lfsr);
		end else if (op == prpc_pkg::OP_CHECK && in_range()) begin
			want           = lfsr_byte(mdl_lfsr, mdl_lfsr);
			r.pattern_byte = want;
			if (rd != prpc_pkg::ALL_ONES_BYTE)
				mdl_all_ff = 1'b0;
			if (rd == want) begin
				mdl_matches++;
			end else if (!mdl_bad_seen) begin
				mdl_bad_seen  = 1'b1;
				mdl_bad_index = mdl_checked[14:0];
			end
			mdl_checked++;
		end
		r.match_count          = mdl_matches;
		r.first_mismatch_index = mdl_bad_seen ? mdl_bad_index : prpc_pkg::NO_INDEX;
		r.all_bytes_ff         = mdl_all_ff;
		r.done_res             = !in_range();
		return r;
	endfunction

	task automatic flag_error(input string what, input logic [39:0] exp_v, input logic [39:0] act_v);
		if (err_count < SHOWN_ERRS)
			$display("%0t: %s differs: expected %0h, got %0h", $time, what, exp_v, act_v);
		err_count++;
	endtask

	// Send one word, optionally after a gap; record its predicted status on accept.
	task automatic send_word(input logic [1:0] op, input logic [7:0] rd);
		bit live;
		if (gaps_on && $urandom_range(0, 6) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= rd;
		do @(posedge clk); while (!s_tready);
		live = op == prpc_pkg::OP_RESTART || op == prpc_pkg::OP_GENERATE ||
			(op == prpc_pkg::OP_CHECK && in_range());
		if (live)
			words_sent++;
		pending_status.push_back(predict_status(op, rd));
	endtask

	// Hold the input idle until every predicted word has come back.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_status.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_rows(input logic [8:0] value);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		mdl_rows = (value < 1) ? 1 : (value > MAX_ROWS) ? MAX_ROWS : int'(value);
	endtask

	// Write pass over the range, read-back pass up to 4 bytes past it, with a fault style.
	task automatic run_march(input int rows, input bit with_noise);
		logic [7:0] written_q[$];
		logic [7:0] rd;
		int         fault_mode;
		int         n_bytes;
		write_rows(rows[8:0]);
		n_bytes    = mdl_rows * ROW_BYTES;
		fault_mode = $urandom_range(0, 3);
		send_word(prpc_pkg::OP_RESTART, 8'($urandom_range(0, 255)));
		for (int i = 0; i < n_bytes; i++) begin
			written_q.push_back(peek_pattern());
			send_word(prpc_pkg::OP_GENERATE, 8'($urandom_range(0, 255)));
		end
		// mostly rewind to the seed; without it every byte is off
		if ($urandom_range(0, 7) != 0)
			send_word(prpc_pkg::OP_RESTART, 8'($urandom_range(0, 255)));
		for (int i = 0; i < n_bytes + $urandom_range(0, 4); i++) begin
			if (with_noise && $urandom_range(0, 24) == 0)
				send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
			if (i >= written_q.size() || fault_mode == 3)
				rd = 8'($urandom_range(0, 255));
			else if (fault_mode == 2)
				rd = prpc_pkg::ALL_ONES_BYTE;
			else
				rd = written_q[i];
			if (fault_mode == 1 && $urandom_range(0, 15) == 0)
				rd = rd ^ (8'h01 << $urandom_range(0, 7));
			send_word(prpc_pkg::OP_CHECK, rd);
		end
	endtask

	task automatic test_reset_state();
		send_word(OP_UNUSED, 8'h00);
	endtask

	task automatic test_generate_restart();
		repeat (3) send_word(prpc_pkg::OP_GENERATE, 8'hFF);
		send_word(prpc_pkg::OP_RESTART, 8'hA5);
		send_word(prpc_pkg::OP_GENERATE, 8'h00);
	endtask

	task automatic test_check_cases();
		send_word(prpc_pkg::OP_RESTART, 8'h00);
		send_word(prpc_pkg::OP_CHECK, peek_pattern());
		send_word(prpc_pkg::OP_CHECK, ~peek_pattern());
		send_word(prpc_pkg::OP_CHECK, peek_pattern());
		send_word(prpc_pkg::OP_CHECK, 8'h00);
		// every byte read as all ones
		send_word(prpc_pkg::OP_RESTART, 8'hFF);
		repeat (3) send_word(prpc_pkg::OP_CHECK, prpc_pkg::ALL_ONES_BYTE);
	endtask

	task automatic test_unused_operation();
		send_word(OP_UNUSED, 8'hFF);
		send_word(OP_UNUSED, 8'hAA);
		send_word(OP_UNUSED, 8'h55);
	endtask

	task automatic test_config_clamp();
		write_rows(9'd0);
		send_word(prpc_pkg::OP_CHECK, 8'h3C);
		write_rows(9'd301);
		send_word(OP_UNUSED, 8'hC3);
		write_rows(9'h100);
		send_word(OP_UNUSED, 8'h0F);
		write_rows(9'd1);
	endtask

	// Lower the row count below progress already made: done sets, checks are dropped.
	task automatic test_shrink_range();
		write_rows(9'd2);
		send_word(prpc_pkg::OP_RESTART, 8'h00);
		for (int i = 0; i < 60; i++)
			send_word(prpc_pkg::OP_CHECK, (i == 37) ? 8'h5A : peek_pattern());
		write_rows(9'd1);
		repeat (3) send_word(prpc_pkg::OP_CHECK, 8'($urandom_range(0, 255)));
		send_word(prpc_pkg::OP_GENERATE, 8'h00);
		send_word(prpc_pkg::OP_RESTART, 8'h00);
	endtask

	task automatic test_max_rows();
		write_rows(9'h1FF);
		send_word(prpc_pkg::OP_RESTART, 8'h00);
		for (int i = 0; i < 30; i++)
			send_word(prpc_pkg::OP_CHECK,
				($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : peek_pattern());
		write_rows(9'd300);
		send_word(prpc_pkg::OP_CHECK, peek_pattern());
	endtask

	task automatic test_random_marches();
		int pick;
		while (words_sent < 750) begin
			gaps_on = ($urandom_range(0, 3) != 0);
			pick    = $urandom_range(0, 19);
			if (pick < 13)
				run_march(1, 1'b1);
			else if (pick < 18)
				run_march(2, 1'b1);
			else if (pick == 18)
				run_march(0, 1'b1);
			else
				run_march((words_sent < 400) ? 3 : 1, 1'b1);
		end
	endtask

	task automatic test_quiet_tail();
		gaps_on = 1'b0;
		run_march(1, 1'b0);
	endtask

	// Output side: random stall bursts.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (gaps_on && $urandom_range(0, 9) == 0) begin
			m_tready   <= 1'b0;
			stall_left <= $urandom_range(0, 8);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		prpc_pkg::result_t want;
		prpc_pkg::result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[38:0];
			if (pending_status.size() == 0) begin
				flag_error("unrequested word", '0, m_tdata);
			end else begin
				want = pending_status.pop_front();
				if (got.pattern_byte !== want.pattern_byte)
					flag_error("pattern_byte", 40'(want.pattern_byte),
						40'(got.pattern_byte));
				if (got.match_count !== want.match_count)
					flag_error("match_count", 40'(want.match_count),
						40'(got.match_count));
				if (got.first_mismatch_index !== want.first_mismatch_index)
					flag_error("first_mismatch_index", 40'(want.first_mismatch_index),
						40'(got.first_mismatch_index));
				if (got.all_bytes_ff !== want.all_bytes_ff)
					flag_error("all_bytes_ff", 40'(want.all_bytes_ff),
						40'(got.all_bytes_ff));
				if (got.done_res !== want.done_res)
					flag_error("done_res", 40'(want.done_res), 40'(got.done_res));
				if (m_tdata[39] !== 1'b0)
					flag_error("pad bit", '0, 40'(m_tdata[39]));
			end
		end
	end

	// Watchdog: stop if no word moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("ram_probe_pattern_checker_unit regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_generate_restart();
		test_check_cases();
		test_unused_operation();
		test_config_clamp();
		test_shrink_range();
		test_max_rows();
		test_random_marches();
		test_quiet_tail();
		settle();
		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("ram_probe_pattern_checker_unit regression: pass");
		else
			$display("ram_probe_pattern_checker_unit regression: fail");
		$finish;
	end

endmodule
